### hdl/asba_pkg.sv
// Shared types and constants for the audio sample binary ALU.
// Used by the top level and by its port checker; depends on nothing.
`timescale 1ns / 1ps

package asba_pkg;

  localparam int unsigned DataWidth = 32;
  localparam int unsigned FracBits  = 16;
  localparam int unsigned DivBits   = DataWidth + FracBits;

  typedef enum logic [2:0] {
    FUNC_MUL = 3'd0,
    FUNC_ADD = 3'd1,
    FUNC_SUB = 3'd2,
    FUNC_REM = 3'd3,
    FUNC_DIV = 3'd4
  } func_t;

  typedef enum logic [1:0] {
    STATUS_OK   = 2'd0,
    STATUS_SAT  = 2'd1,
    STATUS_DIV0 = 2'd2
  } status_t;

  localparam logic signed [63:0] QMax   = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] QMin   = -64'sh0000_0000_8000_0000;
  localparam logic signed [63:0] QRound = 64'sh0000_0000_0000_8000;

endpackage

### hdl/audio_sample_binary_alu_unit.sv
// Top level of the audio sample binary ALU: Q16.16 multiply, add, subtract,
// remainder and divide in one deep pipeline. Depends on asba_pkg.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+------------------------------------
//   input   | in        | in_valid / in_ready  | func, operand_a, operand_b, last_in_block
//   output  | out       | out_valid / out_ready| result, status, last_out
//
// One transfer is accepted in every cycle in which the output register is free
// or taken. The pipe has one preparation stage (operand magnitudes and the 32x32
// product, sum or difference), 48 stages of a restoring divider that produce one
// quotient bit each, and the output register that rounds, signs and saturates.
// All stages advance together and hold when the output register is full and not
// taken, so a stall loses and repeats nothing. Reset clears only the valid bits.
`timescale 1ns / 1ps

module audio_sample_binary_alu_unit (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [2:0]                func,
  input  logic signed [31:0]        operand_a,
  input  logic signed [31:0]        operand_b,
  input  logic                      last_in_block,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [31:0]        result,
  output logic [1:0]                status,
  output logic                      last_out
);
  import asba_pkg::*;

  // The whole pipe moves whenever the output register can take a new value.
  logic enable;
  assign enable   = !out_valid || out_ready;
  assign in_ready = enable;

  // Per-stage registers; index 0 is the preparation stage and index k holds
  // the state after k quotient bits.
  logic                  valid  [DivBits+1];
  logic [2:0]            op     [DivBits+1];
  logic                  sign_a [DivBits+1];
  logic                  sign_b [DivBits+1];
  logic                  bzero  [DivBits+1];
  logic                  last   [DivBits+1];
  logic [DataWidth-1:0]  dvsr   [DivBits+1];
  logic [DivBits-1:0]    work   [DivBits+1];
  logic [DataWidth-1:0]  rem    [DivBits+1];
  logic signed [63:0]    value  [DivBits+1];

  // Preparation: magnitudes for the divider, and the exact value for the
  // multiply, add and subtract paths, which then only travel along.
  logic [DataWidth-1:0] mag_a;
  logic [DataWidth-1:0] mag_b;
  logic signed [63:0]   value_next;
  logic [DivBits-1:0]   work_next;

  always_comb begin
    mag_a = operand_a[31] ? (32'd0 - operand_a) : operand_a;
    mag_b = operand_b[31] ? (32'd0 - operand_b) : operand_b;
    // The remainder divides the raw integers; the divide scales by 2^16 first.
    if (func == FUNC_DIV) begin
      work_next = {mag_a, {FracBits{1'b0}}};
    end else begin
      work_next = {{FracBits{1'b0}}, mag_a};
    end
    case (func)
      FUNC_MUL: value_next = 64'(operand_a) * 64'(operand_b);
      FUNC_ADD: value_next = 64'(operand_a) + 64'(operand_b);
      FUNC_SUB: value_next = 64'(operand_a) - 64'(operand_b);
      default:  value_next = 64'sd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid[0] <= 1'b0;
    end else if (enable) begin
      valid[0] <= in_valid;
    end
    if (enable) begin
      op[0]     <= func;
      sign_a[0] <= operand_a[31];
      sign_b[0] <= operand_b[31];
      bzero[0]  <= (operand_b == 32'sd0);
      last[0]   <= last_in_block;
      dvsr[0]   <= mag_b;
      work[0]   <= work_next;
      rem[0]    <= '0;
      value[0]  <= value_next;
    end
  end

  // Divider: each stage shifts one dividend bit into the partial remainder
  // and shifts one quotient bit into the low end of the work register.
  for (genvar i = 0; i < DivBits; i++) begin : g_div
    logic [DataWidth:0] trial;
    logic [DataWidth:0] diff;

    always_comb begin
      trial = {rem[i], work[i][DivBits-1]};
      diff  = trial - {1'b0, dvsr[i]};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        valid[i+1] <= 1'b0;
      end else if (enable) begin
        valid[i+1] <= valid[i];
      end
      if (enable) begin
        op[i+1]     <= op[i];
        sign_a[i+1] <= sign_a[i];
        sign_b[i+1] <= sign_b[i];
        bzero[i+1]  <= bzero[i];
        last[i+1]   <= last[i];
        dvsr[i+1]   <= dvsr[i];
        value[i+1]  <= value[i];
        if (!diff[DataWidth]) begin
          rem[i+1]  <= diff[DataWidth-1:0];
          work[i+1] <= {work[i][DivBits-2:0], 1'b1};
        end else begin
          rem[i+1]  <= trial[DataWidth-1:0];
          work[i+1] <= {work[i][DivBits-2:0], 1'b0};
        end
      end
    end
  end

  // Output stage: round the product, sign the quotient and remainder, then
  // clamp everything that can overflow.
  logic signed [63:0] wide;
  logic signed [63:0] quot;
  logic signed [63:0] rounded;
  logic signed [31:0] result_next;
  logic [1:0]         status_next;
  logic               clamp;

  always_comb begin
    quot    = 64'({{FracBits{1'b0}}, work[DivBits]});
    rounded = (value[DivBits] + QRound) >>> FracBits;
    clamp   = 1'b1;
    status_next = STATUS_OK;
    case (op[DivBits])
      FUNC_MUL: wide = rounded;
      FUNC_ADD: wide = value[DivBits];
      FUNC_SUB: wide = value[DivBits];
      FUNC_DIV: wide = (sign_a[DivBits] ^ sign_b[DivBits]) ? (64'sd0 - quot) : quot;
      FUNC_REM: begin
        clamp = 1'b0;
        wide  = sign_a[DivBits] ? (64'sd0 - 64'(rem[DivBits])) : 64'(rem[DivBits]);
      end
      default: begin
        clamp = 1'b0;
        wide  = 64'sd0;
      end
    endcase
    result_next = wide[31:0];
    if (clamp && wide > QMax) begin
      result_next = QMax[31:0];
      status_next = STATUS_SAT;
    end else if (clamp && wide < QMin) begin
      result_next = QMin[31:0];
      status_next = STATUS_SAT;
    end
    // A zero divisor overrides everything for the two dividing operations.
    if ((op[DivBits] == FUNC_DIV || op[DivBits] == FUNC_REM) && bzero[DivBits]) begin
      result_next = 32'sd0;
      status_next = STATUS_DIV0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (enable) begin
      out_valid <= valid[DivBits];
    end
    if (enable) begin
      result   <= result_next;
      status   <= status_next;
      last_out <= last[DivBits];
    end
  end

endmodule

### hdl/asba_checker.sv
// Port-level checks for the audio sample binary ALU, bound to the top level.
// Depends on asba_pkg and audio_sample_binary_alu_unit.
`timescale 1ns / 1ps

module asba_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] result,
  input logic [1:0]         status
);
  import asba_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result) && $stable(status))
    else $error("output changed while stalled");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow the output stage");

  a_div0: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STATUS_DIV0 |-> result == 32'sd0)
    else $error("divide by zero without a zero result");

  a_sat: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STATUS_SAT |-> result == 32'sh7FFFFFFF || result == 32'sh80000000)
    else $error("saturation flag without a bound value");

  a_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status != 2'd3)
    else $error("undefined status code");

endmodule

bind audio_sample_binary_alu_unit asba_checker u_asba_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .result    (result),
  .status    (status)
);

### bench/audio_sample_binary_alu_checker.sv
// Port checker for the audio sample binary ALU: predicts each result from the
// accepted input transfers and compares it with the output transfers. Depends on asba_pkg.
`timescale 1ns / 1ps

module audio_sample_binary_alu_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [2:0]         func,
  input  logic signed [31:0] operand_a,
  input  logic signed [31:0] operand_b,
  input  logic               last_in_block,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [31:0] result,
  input  logic [1:0]         status,
  input  logic               last_out,
  output int                 errors,
  output int                 pending
);
  import asba_pkg::*;

  typedef struct packed {
    logic signed [31:0] value;
    status_t            stat;
    logic               last;
  } alu_result_t;

  alu_result_t expected_results[$];

  function automatic logic signed [63:0] clamp_q(input logic signed [63:0] v,
                                                 inout status_t st);
    if (v > QMax) begin
      st = STATUS_SAT;
      return QMax;
    end
    if (v < QMin) begin
      st = STATUS_SAT;
      return QMin;
    end
    return v;
  endfunction

  function automatic alu_result_t compute_alu(input logic [2:0] op,
                                              input logic signed [31:0] a32,
                                              input logic signed [31:0] b32,
                                              input logic lst);
    logic signed [63:0] a;
    logic signed [63:0] b;
    logic signed [63:0] r;
    status_t st;
    alu_result_t res;
    a = a32;
    b = b32;
    r = 0;
    st = STATUS_OK;
    case (op)
      FUNC_MUL: r = clamp_q((a * b + QRound) >>> FracBits, st);
      FUNC_ADD: r = clamp_q(a + b, st);
      FUNC_SUB: r = clamp_q(a - b, st);
      FUNC_REM: begin
        if (b == 0) st = STATUS_DIV0;
        else r = a % b;
      end
      FUNC_DIV: begin
        if (b == 0) st = STATUS_DIV0;
        else r = clamp_q((a * 64'sd65536) / b, st);
      end
      default: r = 0;
    endcase
    res.value = r[31:0];
    res.stat = st;
    res.last = lst;
    return res;
  endfunction

  assign pending = expected_results.size();

  always @(posedge clk) begin
    alu_result_t exp_res;
    if (rst) begin
      errors <= 0;
    end else begin
      if (in_valid && in_ready)
        expected_results.push_back(compute_alu(func, operand_a, operand_b, last_in_block));
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result transfer with none expected: result %h status %0d",
                   $time, result, status);
          errors <= errors + 1;
        end else begin
          exp_res = expected_results.pop_front();
          if (result !== exp_res.value || status !== exp_res.stat ||
              last_out !== exp_res.last) begin
            $display("%0t: mismatch: expected %h/%0d/%0b, actual %h/%0d/%0b", $time,
                     exp_res.value, exp_res.stat, exp_res.last, result, status, last_out);
            errors <= errors + 1;
          end
        end
      end
    end
  end

endmodule

### bench/audio_sample_binary_alu_unit_test.sv
// Testbench top for the audio sample binary ALU: drives input transfers and
// output stalls, and gives the verdict. Depends on asba_pkg and the checker.
`timescale 1ns / 1ps

module audio_sample_binary_alu_unit_test;
  import asba_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0] func = '0;
  logic signed [31:0] operand_a = '0;
  logic signed [31:0] operand_b = '0;
  logic last_in_block = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] result;
  logic [1:0] status;
  logic last_out;
  int errors;
  int pending;
  // The drain phase turns off all idling on both sides.
  logic drain = 1'b0;
  // Set while the receiver is held off for the long stall test.
  logic hold_off = 1'b0;
  // Cycles left in the current receiver stall burst.
  int stall_left = 0;

  always #5 clk = ~clk;

  audio_sample_binary_alu_unit i_dut (.*);

  audio_sample_binary_alu_checker i_checker (.*);

  // Random operand: often a corner value or a small value near zero, else full range.
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0;
      3: return 32'h0001_0000;
      4: return 32'($signed($urandom_range(0, 131071)) - 65536);
      5: return 32'hFFFF_0000;
      default: return $urandom;
    endcase
  endfunction

  // Offers one transfer and waits at the clock edge until it is accepted.
  task automatic send_pair(input logic [2:0] op, input logic [31:0] a,
                           input logic [31:0] b, input logic lst);
    in_valid <= 1'b1;
    func <= op;
    operand_a <= a;
    operand_b <= b;
    last_in_block <= lst;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Sometimes drops valid for a random burst, unless the run is draining.
  task automatic maybe_gap();
    int n;
    if (!drain && $urandom_range(0, 5) == 0) begin
      n = $urandom_range(1, 16);
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Receiver: random stall bursts, and none while draining or holding off.
  always @(posedge clk) begin
    if (rst || hold_off) begin
      out_ready <= 1'b0;
    end else if (drain) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= (stall_left == 1);
    end else if ($urandom_range(0, 15) == 0) begin
      stall_left <= $urandom_range(1, 16);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    logic [31:0] dir_a [0:7];
    logic [31:0] dir_b [0:7];
    int k;
    dir_a = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF,
              32'h0001_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0003_8000};
    dir_b = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF,
              32'hFFFF_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0000};
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: corner operands under every operation code, the
    // unused codes included, and a zero divisor for the remainder.
    for (int op = 0; op < 8; op++) begin
      send_pair(op[2:0], dir_a[op], dir_b[op], op[0]);
      send_pair(op[2:0], dir_a[7 - op], dir_b[op], ~op[0]);
    end
    send_pair(FUNC_REM, 32'hFFFA_0000, 32'h0, 1'b0);
    send_pair(FUNC_REM, 32'hFFFA_0000, 32'h0004_0000, 1'b1);
    send_pair(FUNC_DIV, 32'h7FFF_FFFF, 32'h0000_0001, 1'b0);
    send_pair(FUNC_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);

    // Long receiver hold-off while the sender keeps offering, so the pipe
    // fills and the input stalls.
    hold_off <= 1'b1;
    fork
      begin
        repeat (150) @(posedge clk);
        hold_off <= 1'b0;
      end
      for (k = 0; k < 80; k++)
        send_pair(3'($urandom_range(0, 4)), pick_operand(), pick_operand(),
                  1'($urandom_range(0, 1)));
    join

    // Sender pauses until every expected result has come.
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);

    for (k = 0; k < 700; k++) begin
      if (k == 620) drain <= 1'b1;
      send_pair(3'(($urandom_range(0, 15) == 0) ? $urandom_range(5, 7)
                                                 : $urandom_range(0, 4)),
                pick_operand(), pick_operand(), 1'($urandom_range(0, 1)));
      maybe_gap();
    end
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

### sim.f
hdl/asba_pkg.sv
hdl/audio_sample_binary_alu_unit.sv
hdl/asba_checker.sv
bench/audio_sample_binary_alu_checker.sv
bench/audio_sample_binary_alu_unit_test.sv
